[src/sd_spi_init_sequencer_defines.svh]
// ----------------------------------------------------------------------------
// SD SPI init sequencer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SD_SPI_INIT_SEQUENCER_DEFINES_SVH
`define SD_SPI_INIT_SEQUENCER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDSI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SDSI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/sdsi_pkg.sv]
// ----------------------------------------------------------------------------
// SD SPI init sequencer package
// Types, command codes, status codes and frame tables shared by the modules.
// ----------------------------------------------------------------------------
package sdsi_pkg;

    // Width of the retry counter.
    localparam int RETRY_WIDTH = 16;

    // Command indexes used by the sequence.
    localparam logic [5:0] CMD_GO_IDLE      = 6'd0;
    localparam logic [5:0] CMD_SEND_IF_COND = 6'd8;
    localparam logic [5:0] CMD_SET_BLOCKLEN = 6'd16;
    localparam logic [5:0] CMD_SD_SEND_OP   = 6'd41;
    localparam logic [5:0] CMD_APP_CMD      = 6'd55;
    localparam logic [5:0] CMD_READ_OCR     = 6'd58;

    // Result codes.
    localparam logic [2:0] ST_RUNNING     = 3'd0;
    localparam logic [2:0] ST_OK          = 3'd1;
    localparam logic [2:0] ST_RESET_FAIL  = 3'd2;
    localparam logic [2:0] ST_READY_TIMEOUT = 3'd3;
    localparam logic [2:0] ST_OCR_ERROR   = 3'd4;
    localparam logic [2:0] ST_UNSUPPORTED = 3'd5;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_RESET_RETRY = 2'd0;
    localparam logic [1:0] REG_READY_RETRY = 2'd1;
    localparam logic [1:0] REG_POLL_LIMIT  = 2'd2;
    localparam logic [1:0] REG_WAKE_COUNT  = 2'd3;

    // Special byte values.
    localparam logic [7:0] BYTE_IDLE     = 8'hFF;
    localparam logic [7:0] CMD_START     = 8'h40;
    localparam logic [7:0] R1_IDLE_STATE = 8'h01;
    localparam logic [7:0] R1_READY      = 8'h00;

    // Frame positions: deselect byte, command byte, four argument bytes, CRC.
    localparam logic [3:0] POS_CMD       = 4'd1;
    localparam logic [3:0] POS_ARG_FIRST = 4'd2;
    localparam logic [3:0] POS_ARG_LAST  = 4'd5;
    localparam logic [3:0] FRAME_BYTES   = 4'd7;
    localparam logic [3:0] OCR_BYTES     = 4'd4;

    typedef enum logic [6:0] {
        PH_IDLE  = 7'b0000001,
        PH_WAKE  = 7'b0000010,
        PH_FRAME = 7'b0000100,
        PH_POLL  = 7'b0001000,
        PH_OCR   = 7'b0010000,
        PH_TAIL  = 7'b0100000,
        PH_DONE  = 7'b1000000
    } sdsi_phase_t;

    typedef struct packed {
        logic [7:0]  reset_retry_limit;
        logic [15:0] ready_retry_limit;
        logic [9:0]  response_poll_limit;
        logic [4:0]  wake_byte_count;
    } sdsi_cfg_t;

    typedef struct packed {
        sdsi_phase_t            phase;
        logic [3:0]             byte_position;
        logic [9:0]             poll_count;
        logic [RETRY_WIDTH-1:0] retry_count;
        logic [5:0]             current_command;
        logic [7:0]             last_response;
        logic                   capacity_flag;
        logic [2:0]             result_code;
        logic                   speed_flag;
    } sdsi_state_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       chip_select_high;
        logic       fast_clock;
        logic       finished;
        logic [2:0] status;
        logic       high_capacity;
    } sdsi_result_t;

    // Command argument for each command.
    function automatic logic [31:0] cmd_arg(input logic [5:0] cmd);
        logic [31:0] arg;
        arg = 32'h0000_0000;
        case (cmd)
            CMD_SEND_IF_COND: arg = 32'h0000_01AA;
            CMD_SD_SEND_OP:   arg = 32'h4000_0000;
            CMD_SET_BLOCKLEN: arg = 32'd512;
            default:          arg = 32'h0000_0000;
        endcase
        return arg;
    endfunction

    // CRC byte; only the first two commands need a valid one in SPI mode.
    function automatic logic [7:0] cmd_crc(input logic [5:0] cmd);
        logic [7:0] crc;
        crc = 8'hFF;
        case (cmd)
            CMD_GO_IDLE:      crc = 8'h95;
            CMD_SEND_IF_COND: crc = 8'h87;
            default:          crc = 8'hFF;
        endcase
        return crc;
    endfunction

endpackage

[src/sdsi_cfg_regs.sv]
// ----------------------------------------------------------------------------
// SD SPI init sequencer configuration registers
// APB-style register file holding the retry, poll and wake limits.
// ----------------------------------------------------------------------------
module sdsi_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output sdsi_pkg::sdsi_cfg_t cfg
);
    import sdsi_pkg::*;

    sdsi_cfg_t  cfg_reg;
    logic [1:0] reg_index;
    logic       write_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign write_en  = psel && penable && pwrite;
    assign cfg       = cfg_reg;

    // Register writes during the access cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_retry_limit   <= 8'd200;
            cfg_reg.ready_retry_limit   <= 16'hFFFF;
            cfg_reg.response_poll_limit <= 10'd512;
            cfg_reg.wake_byte_count     <= 5'd10;
        end
        else if (write_en)
        begin
            case (reg_index)
                REG_RESET_RETRY: cfg_reg.reset_retry_limit   <= pwdata[7:0];
                REG_READY_RETRY: cfg_reg.ready_retry_limit   <= pwdata[15:0];
                REG_POLL_LIMIT:  cfg_reg.response_poll_limit <= pwdata[9:0];
                REG_WAKE_COUNT:  cfg_reg.wake_byte_count     <= pwdata[4:0];
                default:         cfg_reg.wake_byte_count     <= cfg_reg.wake_byte_count;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb
    begin
        case (reg_index)
            REG_RESET_RETRY: prdata = {24'd0, cfg_reg.reset_retry_limit};
            REG_READY_RETRY: prdata = {16'd0, cfg_reg.ready_retry_limit};
            REG_POLL_LIMIT:  prdata = {22'd0, cfg_reg.response_poll_limit};
            REG_WAKE_COUNT:  prdata = {27'd0, cfg_reg.wake_byte_count};
            default:         prdata = 32'd0;
        endcase
    end

endmodule

[src/sdsi_step.sv]
// ----------------------------------------------------------------------------
// SD SPI init sequencer step logic
// Computes the next sequencer state and the next byte to send for one item.
// ----------------------------------------------------------------------------
module sdsi_step (
    input  sdsi_pkg::sdsi_cfg_t    cfg,
    input  sdsi_pkg::sdsi_state_t  st,
    input  logic                   action,
    input  logic [7:0]             rx_byte,
    output sdsi_pkg::sdsi_state_t  nxt,
    output sdsi_pkg::sdsi_result_t res
);
    import sdsi_pkg::*;

    logic [9:0]             poll_inc;
    logic [3:0]             pos_inc;
    logic [RETRY_WIDTH-1:0] retry_inc;
    logic [RETRY_WIDTH-1:0] reset_limit;
    logic [RETRY_WIDTH-1:0] ready_limit;
    logic [31:0]            arg;

    assign poll_inc    = st.poll_count + 10'd1;
    assign pos_inc     = st.byte_position + 4'd1;
    assign retry_inc   = st.retry_count + RETRY_WIDTH'(1);
    assign reset_limit = RETRY_WIDTH'(cfg.reset_retry_limit);
    assign ready_limit = RETRY_WIDTH'(cfg.ready_retry_limit);

    // Next state.
    always_comb
    begin
        nxt = st;
        if (!action)
        begin
            // Start: clear everything and begin with the wake bytes.
            nxt.byte_position   = 4'd0;
            nxt.poll_count      = 10'd0;
            nxt.retry_count     = '0;
            nxt.current_command = CMD_GO_IDLE;
            nxt.last_response   = BYTE_IDLE;
            nxt.capacity_flag   = 1'b0;
            nxt.result_code     = ST_RUNNING;
            nxt.speed_flag      = 1'b0;
            nxt.phase           = (cfg.wake_byte_count == 5'd0) ? PH_FRAME : PH_WAKE;
        end
        else
        begin
            case (st.phase)
                PH_WAKE:
                begin
                    nxt.poll_count = poll_inc;
                    if (poll_inc >= {5'd0, cfg.wake_byte_count})
                    begin
                        nxt.phase           = PH_FRAME;
                        nxt.byte_position   = 4'd0;
                        nxt.current_command = CMD_GO_IDLE;
                    end
                end
                PH_FRAME:
                begin
                    nxt.byte_position = pos_inc;
                    if (pos_inc >= FRAME_BYTES)
                    begin
                        nxt.phase      = PH_POLL;
                        nxt.poll_count = 10'd0;
                    end
                end
                PH_POLL:
                begin
                    nxt.poll_count    = poll_inc;
                    nxt.last_response = rx_byte;
                    if (rx_byte != BYTE_IDLE || poll_inc == cfg.response_poll_limit)
                    begin
                        if (st.current_command == CMD_READ_OCR && rx_byte == R1_READY)
                        begin
                            nxt.phase         = PH_OCR;
                            nxt.byte_position = 4'd0;
                        end
                        else
                        begin
                            nxt.phase = PH_TAIL;
                        end
                    end
                end
                PH_OCR:
                begin
                    // The capacity bit is bit 30 of the OCR, in its first byte.
                    if (st.byte_position == 4'd0)
                    begin
                        nxt.capacity_flag = rx_byte[6];
                    end
                    nxt.byte_position = pos_inc;
                    if (pos_inc >= OCR_BYTES)
                    begin
                        nxt.phase = PH_TAIL;
                    end
                end
                PH_TAIL:
                begin
                    // The deselect byte is done; choose the next command.
                    nxt.byte_position = 4'd0;
                    nxt.phase         = PH_FRAME;
                    case (st.current_command)
                        CMD_GO_IDLE:
                        begin
                            nxt.retry_count = retry_inc;
                            if (retry_inc >= reset_limit)
                            begin
                                nxt.phase       = PH_DONE;
                                nxt.byte_position = st.byte_position;
                                nxt.result_code = ST_RESET_FAIL;
                            end
                            else if (st.last_response == R1_IDLE_STATE)
                            begin
                                nxt.retry_count     = '0;
                                nxt.current_command = CMD_SEND_IF_COND;
                            end
                            else
                            begin
                                nxt.current_command = CMD_GO_IDLE;
                            end
                        end
                        CMD_SEND_IF_COND:
                        begin
                            if (st.last_response == R1_IDLE_STATE)
                            begin
                                nxt.retry_count     = '0;
                                nxt.current_command = CMD_APP_CMD;
                            end
                            else
                            begin
                                nxt.phase         = PH_DONE;
                                nxt.byte_position = st.byte_position;
                                nxt.result_code   = ST_UNSUPPORTED;
                            end
                        end
                        CMD_APP_CMD:
                        begin
                            nxt.current_command = CMD_SD_SEND_OP;
                        end
                        CMD_SD_SEND_OP:
                        begin
                            nxt.retry_count = retry_inc;
                            if (retry_inc == ready_limit)
                            begin
                                nxt.phase         = PH_DONE;
                                nxt.byte_position = st.byte_position;
                                nxt.result_code   = ST_READY_TIMEOUT;
                            end
                            else if (st.last_response == R1_READY)
                            begin
                                nxt.current_command = CMD_READ_OCR;
                            end
                            else
                            begin
                                nxt.current_command = CMD_APP_CMD;
                            end
                        end
                        CMD_READ_OCR:
                        begin
                            if (st.last_response != R1_READY)
                            begin
                                nxt.phase         = PH_DONE;
                                nxt.byte_position = st.byte_position;
                                nxt.result_code   = ST_OCR_ERROR;
                            end
                            else
                            begin
                                nxt.current_command = CMD_SET_BLOCKLEN;
                            end
                        end
                        default:
                        begin
                            // Block length command, whatever its answer.
                            nxt.phase         = PH_DONE;
                            nxt.byte_position = st.byte_position;
                            nxt.result_code   = ST_OK;
                            nxt.speed_flag    = 1'b1;
                        end
                    endcase
                end
                default:
                begin
                    nxt = st;
                end
            endcase
        end
    end

    assign arg = cmd_arg(nxt.current_command);

    // Next byte to send, from the new state.
    always_comb
    begin
        res.tx_byte          = 8'h00;
        res.tx_valid         = 1'b1;
        res.chip_select_high = 1'b1;
        case (nxt.phase)
            PH_WAKE, PH_TAIL:
            begin
                res.tx_byte = BYTE_IDLE;
            end
            PH_FRAME:
            begin
                if (nxt.byte_position == 4'd0)
                begin
                    res.tx_byte = BYTE_IDLE;
                end
                else
                begin
                    res.chip_select_high = 1'b0;
                    if (nxt.byte_position == POS_CMD)
                    begin
                        res.tx_byte = CMD_START | {2'b00, nxt.current_command};
                    end
                    else if (nxt.byte_position == POS_ARG_FIRST)
                    begin
                        res.tx_byte = arg[31:24];
                    end
                    else if (nxt.byte_position == POS_ARG_FIRST + 4'd1)
                    begin
                        res.tx_byte = arg[23:16];
                    end
                    else if (nxt.byte_position == POS_ARG_LAST - 4'd1)
                    begin
                        res.tx_byte = arg[15:8];
                    end
                    else if (nxt.byte_position == POS_ARG_LAST)
                    begin
                        res.tx_byte = arg[7:0];
                    end
                    else
                    begin
                        res.tx_byte = cmd_crc(nxt.current_command);
                    end
                end
            end
            PH_POLL, PH_OCR:
            begin
                res.tx_byte          = BYTE_IDLE;
                res.chip_select_high = 1'b0;
            end
            default:
            begin
                res.tx_valid = 1'b0;
            end
        endcase
        res.fast_clock    = nxt.speed_flag;
        res.finished      = (nxt.phase == PH_DONE);
        res.status        = nxt.result_code;
        res.high_capacity = nxt.capacity_flag;
    end

endmodule

[src/sd_spi_init_sequencer.sv]
// ----------------------------------------------------------------------------
// SD SPI init sequencer
// Steps an SD card through SPI-mode initialization, one byte exchange per item.
// ----------------------------------------------------------------------------
// Each input item reports a start request or a completed byte exchange; the
// block answers with exactly one result item that carries the next byte to
// shift out, its chip-select level and the sequence status. An item passes an
// input register, then the combinational step logic, then the result register,
// which it enters when that register is free; a new item can be accepted in
// every cycle, and only a stalled consumer holds items back. The input register
// also takes one item while a result is held by a stalled consumer. Limits are
// set over the APB-style port and should be written while no item is in flight.
`include "sd_spi_init_sequencer_defines.svh"

module sd_spi_init_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input channel.
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [7:0]  rx_byte,
    // Output channel.
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  tx_byte,
    output logic        tx_valid,
    output logic        chip_select_high,
    output logic        fast_clock,
    output logic        finished,
    output logic [2:0]  status,
    output logic        high_capacity
);
    import sdsi_pkg::*;

    sdsi_cfg_t    cfg;
    sdsi_state_t  state_reg;
    sdsi_state_t  state_next;
    sdsi_result_t result_next;
    sdsi_result_t result_reg;

    logic       in_full_reg;
    logic       action_reg;
    logic [7:0] rx_reg;
    logic       out_valid_reg;
    logic       in_accept;
    logic       step_en;

    sdsi_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sdsi_step u_step (
        .cfg     (cfg),
        .st      (state_reg),
        .action  (action_reg),
        .rx_byte (rx_reg),
        .nxt     (state_next),
        .res     (result_next)
    );

    // Handshake: the held item moves on when the result register is free.
    assign step_en   = in_full_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_full_reg && !step_en;
    assign in_accept = in_valid && !in_stall;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_full_reg <= 1'b1;
        end
        else if (step_en)
        begin
            in_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            action_reg <= action;
            rx_reg     <= rx_byte;
        end
    end

    // Sequencer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase           <= PH_IDLE;
            state_reg.byte_position   <= 4'd0;
            state_reg.poll_count      <= 10'd0;
            state_reg.retry_count     <= '0;
            state_reg.current_command <= CMD_GO_IDLE;
            state_reg.last_response   <= BYTE_IDLE;
            state_reg.capacity_flag   <= 1'b0;
            state_reg.result_code     <= ST_RUNNING;
            state_reg.speed_flag      <= 1'b0;
        end
        else if (step_en)
        begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step_en)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign tx_byte          = result_reg.tx_byte;
    assign tx_valid         = result_reg.tx_valid;
    assign chip_select_high = result_reg.chip_select_high;
    assign fast_clock       = result_reg.fast_clock;
    assign finished         = result_reg.finished;
    assign status           = result_reg.status;
    assign high_capacity    = result_reg.high_capacity;

    // Checks on the pipeline and the result encoding.
    `SDSI_ASSERT_NOW(a_stall_cause, in_stall, in_full_reg && out_valid_reg && out_stall,
        "input stalled without a blocked result")
    `SDSI_ASSERT_NEXT(a_step_fills_result, step_en, out_valid_reg,
        "stepped item produced no result")
    `SDSI_ASSERT_NOW(a_finished_quiet, out_valid_reg && finished, !tx_valid,
        "finished result requests a byte")
    `SDSI_ASSERT_NOW(a_fast_only_ok, out_valid_reg && fast_clock, finished && status == ST_OK,
        "fast clock without success")

endmodule
